// ===== hdl/tcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, types and microcode table for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int COLUMNS        = 80;
   localparam int ROWS           = 25;
   localparam int CELLS          = ROWS * COLUMNS;
   localparam int LAST_ROW_START = (ROWS - 1) * COLUMNS;

   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CNT_W  = $clog2(CELLS + 1);

   localparam int CMD_W        = 2;
   localparam int CHAR_W       = 8;
   localparam int ATTR_W       = 8;
   localparam int CELL_W       = CHAR_W + ATTR_W;
   localparam int READ_ROW_W   = 5;
   localparam int READ_COL_W   = 7;
   localparam int CURSOR_ROW_W = 5;
   localparam int CURSOR_COL_W = 7;

   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BACK  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

   localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [ATTR_W-1:0] CLEAR_ATTR   = 8'h0F;

   // micro-operations
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_SWEEP_CLR  = 4'd0;
   localparam logic [OP_W-1:0] OP_WAIT       = 4'd1;
   localparam logic [OP_W-1:0] OP_PUT        = 4'd2;
   localparam logic [OP_W-1:0] OP_SCROLL     = 4'd3;
   localparam logic [OP_W-1:0] OP_BACK_RD    = 4'd4;
   localparam logic [OP_W-1:0] OP_BACK_WR    = 4'd5;
   localparam logic [OP_W-1:0] OP_READ_ISSUE = 4'd6;
   localparam logic [OP_W-1:0] OP_READ_CAP   = 4'd7;
   localparam logic [OP_W-1:0] OP_RESPOND    = 4'd8;

   // program steps
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_INIT     = 4'd0;
   localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd1;
   localparam logic [STEP_W-1:0] STEP_PUT      = 4'd2;
   localparam logic [STEP_W-1:0] STEP_SCROLL   = 4'd3;
   localparam logic [STEP_W-1:0] STEP_BACK_RD  = 4'd4;
   localparam logic [STEP_W-1:0] STEP_BACK_WR  = 4'd5;
   localparam logic [STEP_W-1:0] STEP_CLEAR    = 4'd6;
   localparam logic [STEP_W-1:0] STEP_READ     = 4'd7;
   localparam logic [STEP_W-1:0] STEP_READ_CAP = 4'd8;
   localparam logic [STEP_W-1:0] STEP_RESPOND  = 4'd9;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [STEP_W-1:0] next_step;
      logic [STEP_W-1:0] alt_step;
   } ucode_word_type;

   function automatic ucode_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_word_type w;
      unique case (step)
         STEP_INIT:     w = '{OP_SWEEP_CLR,  STEP_IDLE,     STEP_IDLE};
         STEP_IDLE:     w = '{OP_WAIT,       STEP_IDLE,     STEP_IDLE};
         STEP_PUT:      w = '{OP_PUT,        STEP_RESPOND,  STEP_SCROLL};
         STEP_SCROLL:   w = '{OP_SCROLL,     STEP_RESPOND,  STEP_RESPOND};
         STEP_BACK_RD:  w = '{OP_BACK_RD,    STEP_BACK_WR,  STEP_RESPOND};
         STEP_BACK_WR:  w = '{OP_BACK_WR,    STEP_RESPOND,  STEP_RESPOND};
         STEP_CLEAR:    w = '{OP_SWEEP_CLR,  STEP_RESPOND,  STEP_RESPOND};
         STEP_READ:     w = '{OP_READ_ISSUE, STEP_READ_CAP, STEP_READ_CAP};
         STEP_READ_CAP: w = '{OP_READ_CAP,   STEP_RESPOND,  STEP_RESPOND};
         STEP_RESPOND:  w = '{OP_RESPOND,    STEP_IDLE,     STEP_IDLE};
         default:       w = '{OP_WAIT,       STEP_IDLE,     STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/tcw_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/text_console_writer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text console engine: character screen in RAM, cursor, scroll and clear.
// ----------------------------------------------------------------------------
// One item at a time, run by a microcoded sequencer over a single-write,
// single-read cell RAM. After reset the block blanks the screen with
// req_ready low. Items are a put or newline (which may scroll the
// screen), backspace, read and clear; the scroll and clear walks move one
// cell per cycle through the RAM ports. A new item is taken while an
// earlier result still waits on rsp.
// ----------------------------------------------------------------------------
module text_console_writer_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [tcw_pkg::CMD_W-1:0]        req_cmd,
   input  logic [tcw_pkg::CHAR_W-1:0]       req_char_code,
   input  logic [tcw_pkg::ATTR_W-1:0]       req_attr_byte,
   input  logic [tcw_pkg::READ_ROW_W-1:0]   req_read_row,
   input  logic [tcw_pkg::READ_COL_W-1:0]   req_read_col,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [tcw_pkg::CURSOR_ROW_W-1:0] rsp_cursor_row,
   output logic [tcw_pkg::CURSOR_COL_W-1:0] rsp_cursor_col,
   output logic [tcw_pkg::CHAR_W-1:0]       rsp_cell_char,
   output logic [tcw_pkg::ATTR_W-1:0]       rsp_cell_attr
);
   import tcw_pkg::*;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
   endfunction

   logic [STEP_W-1:0]       step_ff, step_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [CHAR_W-1:0]       char_ff, char_in;
   logic [ATTR_W-1:0]       attr_ff, attr_in;
   logic [ROW_W-1:0]        rrow_ff, rrow_in;
   logic [COL_W-1:0]        rcol_ff, rcol_in;
   logic                    rd_ok_ff, rd_ok_in;
   logic [CHAR_W-1:0]       cell_char_ff, cell_char_in;
   logic [ATTR_W-1:0]       cell_attr_ff, cell_attr_in;
   logic                    pend_ff, pend_in;
   logic [ADDR_W-1:0]       pend_idx_ff, pend_idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CURSOR_ROW_W-1:0] rsp_row_ff, rsp_row_in;
   logic [CURSOR_COL_W-1:0] rsp_col_ff, rsp_col_in;
   logic [CHAR_W-1:0]       rsp_char_ff, rsp_char_in;
   logic [ATTR_W-1:0]       rsp_attr_ff, rsp_attr_in;

   ucode_word_type    uw;
   logic              ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [CELL_W-1:0] ram_wr_data, ram_rd_data;
   logic [CNT_W-1:0]  scroll_src;
   logic [ROW_W-1:0]  prev_row;
   logic [COL_W-1:0]  prev_col;
   logic              wrap;
   logic              rsp_free;

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign uw         = ucode_rom(step_ff);
   assign req_ready  = (uw.op == OP_WAIT);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign scroll_src = (cnt_ff < CNT_W'(LAST_ROW_START)) ? cnt_ff + CNT_W'(COLUMNS) : cnt_ff;
   assign wrap       = (char_ff == NEWLINE_CHAR) || (col_ff == COL_W'(COLUMNS - 1));
   assign prev_row   = (col_ff == '0) ? row_ff - 1'b1 : row_ff;
   assign prev_col   = (col_ff == '0) ? COL_W'(COLUMNS - 1) : col_ff - 1'b1;

   always_comb begin
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      char_in      = char_ff;
      attr_in      = attr_ff;
      rrow_in      = rrow_ff;
      rcol_in      = rcol_ff;
      rd_ok_in     = rd_ok_ff;
      cell_char_in = cell_char_ff;
      cell_attr_in = cell_attr_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_attr_in  = rsp_attr_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cell_addr(row_ff, col_ff);
      ram_wr_data  = {char_ff, attr_ff};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = cell_addr(rrow_ff, rcol_ff);

      unique case (uw.op)
         OP_SWEEP_CLR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cnt_ff[ADDR_W-1:0];
            ram_wr_data = {SPACE_CHAR, CLEAR_ATTR};
            row_in      = '0;
            col_in      = '0;
            if (cnt_ff == CNT_W'(CELLS - 1)) begin
               cnt_in  = '0;
               step_in = uw.next_step;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         OP_WAIT: begin
            if (req_valid) begin
               char_in      = req_char_code;
               attr_in      = req_attr_byte;
               rrow_in      = ROW_W'(req_read_row);
               rcol_in      = COL_W'(req_read_col);
               rd_ok_in     = (int'(req_read_row) < ROWS) && (int'(req_read_col) < COLUMNS);
               cell_char_in = '0;
               cell_attr_in = '0;
               unique case (req_cmd)
                  CMD_PUT:   step_in = STEP_PUT;
                  CMD_BACK:  step_in = STEP_BACK_RD;
                  CMD_CLEAR: step_in = STEP_CLEAR;
                  CMD_READ:  step_in = STEP_READ;
                  default:   step_in = STEP_IDLE;
               endcase
            end
         end
         OP_PUT: begin
            ram_wr_en = (char_ff != NEWLINE_CHAR);
            step_in   = uw.next_step;
            if (wrap) begin
               col_in = '0;
               if (row_ff == ROW_W'(ROWS - 1)) begin
                  step_in = uw.alt_step;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         OP_SCROLL: begin
            if (cnt_ff < CNT_W'(CELLS)) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = scroll_src[ADDR_W-1:0];
               pend_in     = 1'b1;
               pend_idx_in = cnt_ff[ADDR_W-1:0];
               cnt_in      = cnt_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
               cnt_in  = '0;
               step_in = uw.next_step;
            end
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = pend_idx_ff;
               if (pend_idx_ff >= ADDR_W'(LAST_ROW_START)) begin
                  ram_wr_data = {SPACE_CHAR, ram_rd_data[ATTR_W-1:0]};
               end else begin
                  ram_wr_data = ram_rd_data;
               end
            end
         end
         OP_BACK_RD: begin
            if (row_ff == '0 && col_ff == '0) begin
               step_in = uw.alt_step;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = cell_addr(prev_row, prev_col);
               row_in      = prev_row;
               col_in      = prev_col;
               step_in     = uw.next_step;
            end
         end
         OP_BACK_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = {SPACE_CHAR, ram_rd_data[ATTR_W-1:0]};
            step_in     = uw.next_step;
         end
         OP_READ_ISSUE: begin
            ram_rd_en = rd_ok_ff;
            step_in   = uw.next_step;
         end
         OP_READ_CAP: begin
            if (rd_ok_ff) begin
               cell_char_in = ram_rd_data[CELL_W-1 -: CHAR_W];
               cell_attr_in = ram_rd_data[ATTR_W-1:0];
            end
            step_in = uw.next_step;
         end
         OP_RESPOND: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = CURSOR_ROW_W'(row_ff);
               rsp_col_in   = CURSOR_COL_W'(col_ff);
               rsp_char_in  = cell_char_ff;
               rsp_attr_in  = cell_attr_ff;
               step_in      = uw.next_step;
            end
         end
         default: begin
            step_in = STEP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_INIT;
         cnt_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff      <= char_in;
      attr_ff      <= attr_in;
      rrow_ff      <= rrow_in;
      rcol_ff      <= rcol_in;
      rd_ok_ff     <= rd_ok_in;
      cell_char_ff <= cell_char_in;
      cell_attr_ff <= cell_attr_in;
      pend_idx_ff  <= pend_idx_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_attr_ff  <= rsp_attr_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cell_char  = rsp_char_ff;
   assign rsp_cell_attr  = rsp_attr_ff;

endmodule

// ===== hdl/tcw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks for the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic [tcw_pkg::CMD_W-1:0]        req_cmd,
   input logic [tcw_pkg::CHAR_W-1:0]       req_char_code,
   input logic [tcw_pkg::ATTR_W-1:0]       req_attr_byte,
   input logic [tcw_pkg::READ_ROW_W-1:0]   req_read_row,
   input logic [tcw_pkg::READ_COL_W-1:0]   req_read_col,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [tcw_pkg::CURSOR_ROW_W-1:0] rsp_cursor_row,
   input logic [tcw_pkg::CURSOR_COL_W-1:0] rsp_cursor_col,
   input logic [tcw_pkg::CHAR_W-1:0]       rsp_cell_char,
   input logic [tcw_pkg::ATTR_W-1:0]       rsp_cell_attr
);
   import tcw_pkg::*;

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cursor_row)
         && $stable(rsp_cursor_col) && $stable(rsp_cell_char) && $stable(rsp_cell_attr))
      else $error("rsp item changed while stalled");

   // one item in flight
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken before first finished");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_cursor_row) < ROWS)
      else $error("cursor row beyond screen");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_cursor_col) < COLUMNS)
      else $error("cursor column beyond screen");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (.*);
